>>> rtl/core/spre_pkg.sv
// Shared types, constants and codes for the spike and position record expander.
package spre_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int STAMP_W = 32;
  localparam int CNT_W = 4;
  localparam int NUM_CLUSTERS = 4;
  localparam int CIDX_W = $clog2(NUM_CLUSTERS);
  localparam int CLUSTER_W = 3;
  localparam logic [STAMP_W-1:0] INTERVAL_RESET = 32'd10922667;

  // Record kinds.
  localparam logic REC_SPIKE = 1'b0;
  localparam logic REC_POS = 1'b1;

  // Cluster number carried by a position record.
  localparam logic [CLUSTER_W-1:0] CLUSTER_NONE = 3'd0;

  typedef struct packed {
    logic [7:0]       red_x;
    logic [7:0]       red_y;
    logic [7:0]       green_x;
    logic [7:0]       green_y;
    logic [CNT_W-1:0] spikes_one;
    logic [CNT_W-1:0] spikes_two;
    logic [CNT_W-1:0] spikes_three;
    logic [CNT_W-1:0] spikes_four;
  } in_t;

  typedef struct packed {
    logic                 rec_kind;
    logic [CLUSTER_W-1:0] cluster;
    logic [STAMP_W-1:0]   stamp;
    logic [7:0]           out_red_x;
    logic [7:0]           out_red_y;
    logic [7:0]           out_green_x;
    logic [7:0]           out_green_y;
    logic                 last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_EMIT,
    ST_POS
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch the sample and advance the time accumulator
    logic round;    // register the rounded time stamp
    logic spike;    // load a spike record for the current cluster
    logic advance;  // step to the next cluster
    logic pos;      // load the position record
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cur_zero;      // current cluster has no spikes left
    logic last_cluster;  // current cluster is the fourth
    logic out_free;      // output register can take a record this cycle
  } status_t;

endpackage

>>> rtl/core/spre_ctrl.sv
// Controller state machine that sequences accept, rounding and record emission.
module spre_ctrl
  import spre_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.cur_zero) begin
          if (status.last_cluster) begin
            state_next = ST_POS;
          end else begin
            cmd.advance = 1'b1;
          end
        end else if (status.out_free) begin
          cmd.spike = 1'b1;
        end
      end
      ST_POS: begin
        if (status.out_free) begin
          cmd.pos = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/spre_dp.sv
// Datapath: interval register, time accumulator, spike counters and output register.
module spre_dp
  import spre_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [STAMP_W-1:0] cfg_data,
  input  in_t                in_data,
  input  cmd_t               cmd,
  output status_t            status,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  localparam int ACC_W = STAMP_W + FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);

  logic [STAMP_W-1:0] interval;
  logic [ACC_W-1:0]   acc;
  logic [STAMP_W-1:0] rounded;
  logic [CNT_W-1:0]   cnt [NUM_CLUSTERS];
  logic [CIDX_W-1:0]  cidx;
  in_t                sample;

  logic [ACC_W-1:0]   acc_half;
  logic [STAMP_W-1:0] spike_stamp;

  assign acc_half = acc + HALF;
  assign spike_stamp = rounded - STAMP_W'(1);

  assign status.cur_zero = (cnt[cidx] == '0);
  assign status.last_cluster = (cidx == CIDX_W'(NUM_CLUSTERS - 1));
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
      acc <= '0;
    end else begin
      if (cfg_we) begin
        interval <= cfg_data;
      end
      if (cmd.accept) begin
        acc <= acc + ACC_W'(interval);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample <= in_data;
      cnt[0] <= in_data.spikes_one;
      cnt[1] <= in_data.spikes_two;
      cnt[2] <= in_data.spikes_three;
      cnt[3] <= in_data.spikes_four;
      cidx <= '0;
    end else begin
      if (cmd.spike) begin
        cnt[cidx] <= cnt[cidx] - CNT_W'(1);
      end
      if (cmd.advance) begin
        cidx <= cidx + CIDX_W'(1);
      end
    end
    if (cmd.round) begin
      rounded <= acc_half[FRAC_BITS +: STAMP_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.spike || cmd.pos) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.spike) begin
      out_data.rec_kind <= REC_SPIKE;
      out_data.cluster <= CLUSTER_W'(cidx) + CLUSTER_W'(1);
      out_data.stamp <= spike_stamp;
      out_data.out_red_x <= '0;
      out_data.out_red_y <= '0;
      out_data.out_green_x <= '0;
      out_data.out_green_y <= '0;
      out_data.last <= 1'b0;
    end else if (cmd.pos) begin
      out_data.rec_kind <= REC_POS;
      out_data.cluster <= CLUSTER_NONE;
      out_data.stamp <= rounded;
      out_data.out_red_x <= sample.red_x;
      out_data.out_red_y <= sample.red_y;
      out_data.out_green_x <= sample.green_x;
      out_data.out_green_y <= sample.green_y;
      out_data.last <= 1'b1;
    end
  end

endmodule

>>> rtl/core/spike_position_record_expander.sv
// Each sample passes through accept and rounding, then the spike records of cluster
// one to four with a step at the end of each cluster, then the position record. A new
// sample is taken only after the previous one's position record is loaded. The
// controller takes one step per cycle unless an output stall holds it, and that
// sets the rate.
// Reset is synchronous and active high; it clears the time accumulator, loads the
// default sample interval and empties the output register.
module spike_position_record_expander
  import spre_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: writes the sample interval, in fixed point with FRAC_BITS
  // fraction bits. Writes are expected only while the block is idle.
  input  logic               cfg_we,
  input  logic [STAMP_W-1:0] cfg_data,
  // Sample requests.
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  // Record requests: spike records first, cluster one to four, then the
  // position record, which carries last.
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data
);

  cmd_t    cmd;
  status_t status;

  // The controller walks each sample through accept, rounding, one step per
  // spike or cluster change, and finally the position record. It only takes a
  // new sample once the position record of the previous one sits in the
  // output register, so that register may still be waiting while the next
  // request comes in.
  spre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath advances the accumulator on accept, rounds it by adding one
  // half in the following cycle, and builds records from the latched sample
  // and its four spike counters. Spike records carry the rounded time minus
  // one, which wraps to all ones when the rounded time is zero.
  spre_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/spre_chk.sv
// Port-level checker for the record expander and its bind to the top level.
module spre_chk
  import spre_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input out_t               out_data
);

  // A stalled record holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("record changed while stalled");

  // Only the position record is marked last.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == (out_data.rec_kind == REC_POS)))
    else $error("last flag does not match record kind");

  // Spike records name a cluster from one to four and carry no coordinates.
  a_spike_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.rec_kind == REC_SPIKE) |->
      ((out_data.cluster >= 3'd1) && (out_data.cluster <= 3'd4) &&
       (out_data.out_red_x == '0) && (out_data.out_red_y == '0) &&
       (out_data.out_green_x == '0) && (out_data.out_green_y == '0)))
    else $error("malformed spike record");

  // A sample always produces at least its position record, so the block is
  // busy in the cycle after it takes one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (!rst && in_valid && !in_stall) |=> in_stall)
    else $error("sample taken while previous one still in progress");

endmodule

bind spike_position_record_expander spre_chk u_spre_chk (.*);

>>> tb/tb_spike_position_record_expander.sv
// Self-checking testbench for the spike and position record expander.
module tb_spike_position_record_expander;
  timeunit 1ns;
  timeprecision 1ps;

  import spre_pkg::*;

  // The block is used at its default fraction width; the model below follows it.
  localparam int FB = FRAC_BITS_DEF;
  localparam int ACC_W = STAMP_W + FB;
  // Watchdog on the whole run; it must allow for samples of up to 61 records under
  // the heaviest stalling.
  localparam int CYCLE_LIMIT = 500_000;

  logic  clk;
  logic  rst = 1'b1;
  logic  cfg_we = 1'b0;
  logic  [STAMP_W-1:0] cfg_data = '0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  spike_position_record_expander dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Our own copy of the block's state: the Q32.16 time accumulator and the
  // sample interval register.
  logic [ACC_W-1:0]   time_acc;
  logic [STAMP_W-1:0] interval_now;

  // Records that the block still owes us, oldest first.
  out_t records_due [$];

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Advance the accumulator by one sample and queue the records that sample
  // must produce: one spike record per counted spike, cluster one through four,
  // then the position record carrying last. When the caller worked the stamp
  // out by hand, that value is used for the expected records instead of ours.
  function automatic void expand_sample(input in_t s, input bit hand_stamp,
                                        input logic [STAMP_W-1:0] stamp_by_hand);
    logic [ACC_W:0]     biased;
    logic [STAMP_W-1:0] now_stamp;
    logic [CNT_W-1:0]   counts [NUM_CLUSTERS];
    out_t               r;
    time_acc = time_acc + ACC_W'(interval_now);
    // Add one half in a wider word; the carry out of the top is dropped, so a
    // time just below the wrap point rounds to zero.
    biased = {1'b0, time_acc} + ((ACC_W + 1)'(1) << (FB - 1));
    now_stamp = biased[FB +: STAMP_W];
    if (hand_stamp) begin
      now_stamp = stamp_by_hand;
    end
    counts[0] = s.spikes_one;
    counts[1] = s.spikes_two;
    counts[2] = s.spikes_three;
    counts[3] = s.spikes_four;
    for (int c = 0; c < NUM_CLUSTERS; c++) begin
      for (int k = 0; k < int'(counts[c]); k++) begin
        r = '0;
        r.rec_kind = REC_SPIKE;
        r.cluster = CLUSTER_W'(c + 1);
        // A rounded time of zero wraps the spike stamp to all ones.
        r.stamp = now_stamp - STAMP_W'(1);
        records_due.push_back(r);
      end
    end
    r = '0;
    r.rec_kind = REC_POS;
    r.cluster = CLUSTER_NONE;
    r.stamp = now_stamp;
    r.out_red_x = s.red_x;
    r.out_red_y = s.red_y;
    r.out_green_x = s.green_x;
    r.out_green_y = s.green_y;
    r.last = 1'b1;
    records_due.push_back(r);
  endfunction

  // Offer one request, after a random gap, and hold it until it is taken.
  // The gap is decided before valid rises, so valid never follows stall.
  task automatic send(input in_t s, input bit hand_stamp,
                      input logic [STAMP_W-1:0] stamp_by_hand);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
    expand_sample(s, hand_stamp, stamp_by_hand);
  endtask

  // Stop offering requests and wait for every owed record. Always waits on the clock
  // so valid is never lowered and raised in the same step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (records_due.size() != 0);
  endtask

  // Register writes only land on an idle block: drain, let it settle, then write.
  task automatic write_interval(input logic [STAMP_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    interval_now = value;
  endtask

  // Random sample: coordinates cover the full byte range; spike counts come
  // in a mix of empty samples, full samples, fully random counts and light
  // traffic, so both the short and the long expansions are common.
  function automatic in_t random_sample();
    in_t s;
    int  shape;
    s.red_x = 8'($urandom);
    s.red_y = 8'($urandom);
    s.green_x = 8'($urandom);
    s.green_y = 8'($urandom);
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      s.spikes_one = '0;
      s.spikes_two = '0;
      s.spikes_three = '0;
      s.spikes_four = '0;
    end else if (shape == 1) begin
      s.spikes_one = '1;
      s.spikes_two = '1;
      s.spikes_three = '1;
      s.spikes_four = '1;
    end else if (shape < 5) begin
      s.spikes_one = CNT_W'($urandom);
      s.spikes_two = CNT_W'($urandom);
      s.spikes_three = CNT_W'($urandom);
      s.spikes_four = CNT_W'($urandom);
    end else begin
      s.spikes_one = CNT_W'($urandom_range(0, 3));
      s.spikes_two = CNT_W'($urandom_range(0, 3));
      s.spikes_three = CNT_W'($urandom_range(0, 3));
      s.spikes_four = CNT_W'($urandom_range(0, 3));
    end
    return s;
  endfunction

  task automatic compare_field(input string field, input logic [STAMP_W-1:0] want,
                               input logic [STAMP_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  // Every record taken from the block is held against the oldest owed one.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (records_due.size() == 0) begin
        fail_count++;
        $display("%0t: expected no record, got %h", $time, out_data);
      end else begin
        want = records_due.pop_front();
        compare_field("rec_kind", STAMP_W'(want.rec_kind), STAMP_W'(out_data.rec_kind));
        compare_field("cluster", STAMP_W'(want.cluster), STAMP_W'(out_data.cluster));
        compare_field("stamp", want.stamp, out_data.stamp);
        compare_field("out_red_x", STAMP_W'(want.out_red_x),
                      STAMP_W'(out_data.out_red_x));
        compare_field("out_red_y", STAMP_W'(want.out_red_y),
                      STAMP_W'(out_data.out_red_y));
        compare_field("out_green_x", STAMP_W'(want.out_green_x),
                      STAMP_W'(out_data.out_green_x));
        compare_field("out_green_y", STAMP_W'(want.out_green_y),
                      STAMP_W'(out_data.out_green_y));
        compare_field("last", STAMP_W'(want.last), STAMP_W'(out_data.last));
      end
    end
  end

  // Receiver back-pressure, drawn fresh every cycle at the current rate.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // One directed step: either a write of the interval register or a sample.
  // Where the position stamp was worked out by hand it is typed in and used
  // as the expectation; otherwise the model supplies it.
  typedef struct {
    bit                 is_write;
    logic [STAMP_W-1:0] value;
    in_t                sample;
    bit                 hand_stamp;
    logic [STAMP_W-1:0] stamp;
  } step_t;

  localparam int NUM_DIRECTED = 19;
  step_t directed [NUM_DIRECTED];

  // Idling mixes for the random phases: none, sender idle, receiver stalling,
  // and both at a light rate.
  int phase_send [4] = '{0, 69, 0, 14};
  int phase_recv [4] = '{0, 0, 69, 14};

  initial begin
    time_acc = '0;
    interval_now = INTERVAL_RESET;

    // Sample layout in the hex below: red_x red_y green_x green_y, then the
    // four spike counts as nibbles, cluster one first.
    directed = '{
      // Zero interval straight after reset: the time stays at zero, so the
      // spike stamps wrap to all ones.
      '{1'b1, 32'd0, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'h11223344_2001, 1'b1, 32'd0},
      '{1'b1, INTERVAL_RESET, 48'h0, 1'b0, 32'd0},
      // First timed sample: 166.67 rounds to 167, no spikes.
      '{1'b0, 32'd0, 48'h00000000_0000, 1'b1, 32'd167},
      // All fields at their top: fifteen spikes per cluster, 61 records.
      '{1'b0, 32'd0, 48'hFFFFFFFF_FFFF, 1'b1, 32'd333},
      // Zero interval: time stands still.
      '{1'b1, 32'd0, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'h12345678_1000, 1'b1, 32'd333},
      '{1'b0, 32'd0, 48'hA55AC33C_0F00, 1'b1, 32'd333},
      // Smallest nonzero interval: one fraction step, still rounds to 333.
      '{1'b1, 32'd1, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'h01020304_0001, 1'b1, 32'd333},
      // Exactly one unit per sample.
      '{1'b1, 32'h0001_0000, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'h80808080_00FF, 1'b1, 32'd334},
      // Half a unit per sample moves the fraction across the rounding point.
      '{1'b1, 32'h0000_8000, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'h7F7F7F7F_0010, 1'b1, 32'd335},
      '{1'b0, 32'd0, 48'hFE01FE01_3000, 1'b1, 32'd335},
      // Largest interval.
      '{1'b1, 32'hFFFF_FFFF, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'hFF00FF00_F0F0, 1'b1, 32'd65871},
      // Back to the reset value, then one sample left to the model.
      '{1'b1, INTERVAL_RESET, 48'h0, 1'b0, 32'd0},
      '{1'b0, 32'd0, 48'h01FE7FFE_8421, 1'b0, 32'd0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed[i].is_write) begin
        write_interval(directed[i].value);
      end else begin
        send(directed[i].sample, directed[i].hand_stamp, directed[i].stamp);
      end
    end

    // Random phases, each behind its own interval setting and idling mix.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_interval($urandom);
        1: write_interval(32'hFFFF_FFFF);
        2: write_interval($urandom_range(1, 32'h0040_0000));
        default: write_interval(INTERVAL_RESET);
      endcase
      send_idle_pct = phase_send[p];
      recv_stall_pct <= phase_recv[p];
      for (int n = 0; n < 115; n++) begin
        // Now and then the sender holds off until the block has fully emptied.
        if ($urandom_range(0, 19) == 0) begin
          drain();
        end
        send(random_sample(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> spike_position_record_expander.f
rtl/core/spre_pkg.sv
rtl/core/spre_ctrl.sv
rtl/core/spre_dp.sv
rtl/core/spike_position_record_expander.sv
rtl/core/spre_chk.sv
tb/tb_spike_position_record_expander.sv
